FILE: rtl/fifo_queue_with_sorted_insert_macros.svh
// ---------------------------------------------------------------------------
// fifo_queue_with_sorted_insert assertion macros
// Shared concurrent assertion forms, clocked on clk, reset rst.
// ---------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SORTED_INSERT_MACROS_SVH
`define FIFO_QUEUE_WITH_SORTED_INSERT_MACROS_SVH

// Check that holds outside reset
`define FQSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also covers reset itself
`define FQSI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fqsi_pkg.sv
// ---------------------------------------------------------------------------
// fqsi_pkg
// Shared types, constants and helpers of the sorted-insert queue.
// ---------------------------------------------------------------------------
package fqsi_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_INS = 2'd1,
    CMD_DEQ = 2'd2,
    CMD_CLR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_POS,
    RD_IM1,
    RD_HEAD
  } rd_sel_t;

  // Memory write address/data source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_TAIL,
    WR_POS,
    WR_SHIFT
  } wr_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    deq_take;
    logic    clr;
    logic    pos_clr;
    logic    pos_inc;
    logic    i_load;
    logic    i_dec;
    logic    st_full;
    logic    st_empty;
    logic    out_load;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic pos_end;
    logic i_at_pos;
    logic less;
  } sts_t;

  // Store position of a logical index counted from the head
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] ofs);
    logic [IDX_W:0] s;
    s = {1'b0, head} + (IDX_W+1)'(ofs);
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/fqsi_datapath.sv
// ---------------------------------------------------------------------------
// fqsi_datapath
// Entry store, head/count registers, scan and shift pointers, result regs.
// ---------------------------------------------------------------------------
module fqsi_datapath
  import fqsi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_t                     ctl,
  input  logic [1:0]               cmd_in,
  input  logic signed [DATA_W-1:0] value_in,
  output sts_t                     sts,
  output logic signed [DATA_W-1:0] head_value,
  output logic signed [DATA_W-1:0] removed_value,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         count
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] removed_q;
  logic signed [DATA_W-1:0] wr_data;
  cmd_t                     cmd_q;
  status_t                  st_q;
  logic [IDX_W-1:0]         head_idx;
  logic [IDX_W-1:0]         head_idx_next;
  logic [CNT_W-1:0]         ent_cnt;
  logic [CNT_W-1:0]         pos;
  logic [CNT_W-1:0]         idx;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         wr_addr;

  // Status back to the controller
  assign sts.cmd      = cmd_q;
  assign sts.full     = (ent_cnt == CNT_W'(DEPTH));
  assign sts.empty    = (ent_cnt == '0);
  assign sts.pos_end  = (pos == ent_cnt);
  assign sts.i_at_pos = (idx == pos);
  assign sts.less     = (rd_data < value_q);

  assign head_idx_next = slot(head_idx, CNT_W'(1));

  // Read address select
  always_comb begin
    case (ctl.rd_sel)
      RD_POS:  rd_addr = slot(head_idx, pos);
      RD_IM1:  rd_addr = slot(head_idx, idx - CNT_W'(1));
      default: rd_addr = head_idx;
    endcase
  end

  // Write address/data select
  always_comb begin
    case (ctl.wr_sel)
      WR_TAIL: begin
        wr_addr = slot(head_idx, ent_cnt);
        wr_data = value_q;
      end
      WR_SHIFT: begin
        wr_addr = slot(head_idx, idx);
        wr_data = rd_data;
      end
      default: begin
        wr_addr = slot(head_idx, pos);
        wr_data = value_q;
      end
    endcase
  end

  // Entry store: one write, one registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_sel != WR_NONE) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_sel != RD_NONE) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
      ent_cnt  <= '0;
    end else if (ctl.clr) begin
      head_idx <= '0;
      ent_cnt  <= '0;
    end else if (ctl.deq_take) begin
      head_idx <= head_idx_next;
      ent_cnt  <= ent_cnt - CNT_W'(1);
    end else if (ctl.cnt_inc) begin
      ent_cnt  <= ent_cnt + CNT_W'(1);
    end
  end

  // Command beat, pointers and result fields
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q     <= cmd_t'(cmd_in);
      value_q   <= value_in;
      st_q      <= ST_OK;
      removed_q <= '0;
    end
    if (ctl.st_full) begin
      st_q <= ST_FULL;
    end
    if (ctl.st_empty) begin
      st_q <= ST_EMPTY;
    end
    if (ctl.deq_take) begin
      removed_q <= rd_data;
    end
    if (ctl.pos_clr) begin
      pos <= '0;
    end else if (ctl.pos_inc) begin
      pos <= pos + CNT_W'(1);
    end
    if (ctl.i_load) begin
      idx <= ent_cnt;
    end else if (ctl.i_dec) begin
      idx <= idx - CNT_W'(1);
    end
    if (ctl.out_load) begin
      head_value    <= (ent_cnt != '0) ? rd_data : '0;
      removed_value <= removed_q;
      status        <= st_q;
      count         <= ent_cnt;
    end
  end

endmodule

FILE: rtl/fqsi_ctrl.sv
// ---------------------------------------------------------------------------
// fqsi_ctrl
// Command sequencer: decode, scan, shift, head readback and result strobe.
// ---------------------------------------------------------------------------
module fqsi_ctrl
  import fqsi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy,
  output logic done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DEQ_TAKE,
    S_HEAD_RD,
    S_HEAD_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_HEAD_RD;
        case (sts.cmd)
          CMD_ENQ: begin
            if (sts.full) begin
              ctl.st_full = 1'b1;
            end else begin
              ctl.wr_sel  = WR_TAIL;
              ctl.cnt_inc = 1'b1;
            end
          end
          CMD_INS: begin
            if (sts.full) begin
              ctl.st_full = 1'b1;
            end else begin
              ctl.pos_clr = 1'b1;
              state_next  = S_SCAN_RD;
            end
          end
          CMD_DEQ: begin
            if (sts.empty) begin
              ctl.st_empty = 1'b1;
            end else begin
              ctl.rd_sel = RD_HEAD;
              state_next = S_DEQ_TAKE;
            end
          end
          default: ctl.clr = 1'b1;
        endcase
      end
      // Forward scan for the first entry not less than the value
      S_SCAN_RD: begin
        if (sts.pos_end) begin
          ctl.i_load = 1'b1;
          state_next = S_SHIFT_RD;
        end else begin
          ctl.rd_sel = RD_POS;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.less) begin
          ctl.pos_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end else begin
          ctl.i_load  = 1'b1;
          state_next  = S_SHIFT_RD;
        end
      end
      // Move entries back one place from the tail down to the insert point
      S_SHIFT_RD: begin
        if (sts.i_at_pos) begin
          ctl.wr_sel  = WR_POS;
          ctl.cnt_inc = 1'b1;
          state_next  = S_HEAD_RD;
        end else begin
          ctl.rd_sel  = RD_IM1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ctl.wr_sel = WR_SHIFT;
        ctl.i_dec  = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_DEQ_TAKE: begin
        ctl.deq_take = 1'b1;
        state_next   = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        ctl.rd_sel = RD_HEAD;
        state_next = S_HEAD_OUT;
      end
      S_HEAD_OUT: begin
        ctl.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_HEAD_OUT);
    end
  end

endmodule

FILE: rtl/fifo_queue_with_sorted_insert.sv
// ---------------------------------------------------------------------------
// fifo_queue_with_sorted_insert
// Bounded queue of signed 32-bit values with enqueue, sorted insert,
// dequeue and clear; one result beat per command.
//
//   channel   handshake          payload
//   command   start / busy       cmd, value
//   result    done (1 cycle)     head_value, removed_value, status, count
//
// Enqueue, clear, full and empty cases pass straight from decode to the head
// readback; dequeue adds a take step; sorted insert scans forward for the
// insert point and shifts the later entries back one place at a time through
// the entry memory. Reset (rst, synchronous) empties the queue and idles the
// sequencer; no clearing pass. Results cannot be stalled; a new command
// may be accepted in the cycle that done is high.
// ---------------------------------------------------------------------------
`include "fifo_queue_with_sorted_insert_macros.svh"

module fifo_queue_with_sorted_insert
  import fqsi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               cmd,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic signed [DATA_W-1:0] head_value,
  output logic signed [DATA_W-1:0] removed_value,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         count
);

  ctl_t ctl;
  sts_t sts;

  fqsi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  fqsi_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cmd_in        (cmd),
    .value_in      (value),
    .sts           (sts),
    .head_value    (head_value),
    .removed_value (removed_value),
    .status        (status),
    .count         (count)
  );

  // Checks
  `FQSI_ASSERT_RST(a_rst_idle, rst |=> (!busy && !done), "not idle after reset")
  `FQSI_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command not busy")
  `FQSI_ASSERT(a_done_idle, done |-> !busy, "result beat while busy")
  `FQSI_ASSERT(a_full_cnt, (done && status == ST_FULL) |-> (count == CNT_W'(DEPTH)), "full status with room")
  `FQSI_ASSERT(a_empty_res, (done && status == ST_EMPTY) |-> (count == '0 && removed_value == '0), "empty status mismatch")

endmodule

FILE: dv/fifo_queue_with_sorted_insert_test.sv
// ---------------------------------------------------------------------------
// fifo_queue_with_sorted_insert_test
// Self-checking bench for the sorted-insert queue. A directed table covers
// reset, field extremes, ties, unsorted contents, full and empty cases and
// clear; a long random run with fill and drain phases follows. Result beats
// are checked against a bench shadow queue or the row's own expected values.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module fifo_queue_with_sorted_insert_test;
  import fqsi_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic signed [DATA_W-1:0] head;
    logic signed [DATA_W-1:0] removed;
    status_t                  status;
    logic [CNT_W-1:0]         count;
  } queue_result_t;

  typedef struct {
    cmd_t          op;
    logic [31:0]   data;
    bit            typed;
    queue_result_t want;
  } stim_row_t;

  logic                     clk;
  logic                     rst   = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               cmd   = CMD_ENQ;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] head_value;
  logic signed [DATA_W-1:0] removed_value;
  logic [1:0]               status;
  logic [CNT_W-1:0]         count;

  // Shadow copy of the queue
  logic signed [DATA_W-1:0] shadow_store [DEPTH];
  int                       shadow_head;
  int                       shadow_count;

  queue_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int            fail_count;
  bit            no_idle;

  fifo_queue_with_sorted_insert dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .value         (value),
    .done          (done),
    .head_value    (head_value),
    .removed_value (removed_value),
    .status        (status),
    .count         (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Store position of a logical offset from the shadow head
  function automatic logic [IDX_W-1:0] shadow_slot(int ofs);
    return IDX_W'((shadow_head + ofs) % DEPTH);
  endfunction

  // Apply one command to the shadow queue, return the result it produces
  function automatic queue_result_t apply_queue_cmd(cmd_t op, logic signed [DATA_W-1:0] v);
    queue_result_t r;
    int            pos;
    r.head    = '0;
    r.removed = '0;
    r.status  = ST_OK;
    r.count   = '0;
    case (op)
      CMD_ENQ, CMD_INS: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == CMD_ENQ) begin
          shadow_store[shadow_slot(shadow_count)] = v;
          shadow_count++;
        end else begin
          // stop at the first entry not less than v, ahead of ties
          pos = 0;
          while (pos < shadow_count && shadow_store[shadow_slot(pos)] < v) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_store[shadow_slot(i)] = shadow_store[shadow_slot(i - 1)];
          end
          shadow_store[shadow_slot(pos)] = v;
          shadow_count++;
        end
      end
      CMD_DEQ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed   = shadow_store[shadow_slot(0)];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      default: begin
        shadow_head  = 0;
        shadow_count = 0;
      end
    endcase
    if (shadow_count != 0) r.head = shadow_store[shadow_slot(0)];
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic add_row(cmd_t op, logic [31:0] data, bit typed = 1'b0,
                         logic [31:0] h = '0, status_t s = ST_OK,
                         logic [CNT_W-1:0] n = '0);
    stim_row_t row;
    row.op           = op;
    row.data         = data;
    row.typed        = typed;
    row.want.head    = h;
    row.want.removed = '0;
    row.want.status  = s;
    row.want.count   = n;
    directed_rows.push_back(row);
  endtask

  // Drive one command beat, wait for acceptance, record the expected result
  task automatic issue_cmd(cmd_t op, logic [31:0] data, bit typed, queue_result_t want);
    queue_result_t predicted;
    // each idle leaves the block waiting with start low when it could take a beat
    while (!no_idle && $urandom_range(99) < 14) begin
      start <= 1'b0;
      do @(posedge clk); while (busy !== 1'b0);
    end
    start <= 1'b1;
    cmd   <= op;
    value <= data;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_queue_cmd(op, data);
    pending_results.push_back(typed ? want : predicted);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'(int'($urandom_range(16)) - 8);   // dense, many ties
      4: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("tb: unexpected result beat at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        if (head_value !== want.head || removed_value !== want.removed ||
            status !== want.status || count !== want.count) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("tb: mismatch at %0t: head %h/%h removed %h/%h status %0d/%0d count %0d/%0d",
                     $realtime, want.head, head_value, want.removed, removed_value,
                     want.status, status, want.count, count);
        end
      end
    end
  end

  // Stimulus
  initial begin
    cmd_t          op;
    int            bias;
    int            roll;
    queue_result_t none;

    none.head    = '0;
    none.removed = '0;
    none.status  = ST_OK;
    none.count   = '0;
    shadow_head  = 0;
    shadow_count = 0;
    fail_count   = 0;
    no_idle      = 1'b0;
    foreach (shadow_store[i]) shadow_store[i] = '0;

    // dequeue straight out of reset
    add_row(CMD_DEQ, 32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, CNT_W'(0));
    add_row(CMD_INS, 32'h0000_0000);
    add_row(CMD_ENQ, 32'h7FFF_FFFF);
    add_row(CMD_INS, 32'h8000_0000);             // new head
    add_row(CMD_INS, 32'hFFFF_FFFF);
    add_row(CMD_INS, 32'h0000_0000);             // tie goes ahead
    add_row(CMD_ENQ, 32'hFFFF_FFFB);             // contents now unsorted
    add_row(CMD_INS, 32'd100);                   // stops at max, not at tail
    add_row(CMD_DEQ, 32'hDEAD_BEEF);
    // fill up; head stays at -1
    add_row(CMD_ENQ, 32'hAAAA_AAAA);
    add_row(CMD_INS, 32'h5555_5555);
    add_row(CMD_ENQ, 32'h0000_0001);
    add_row(CMD_INS, 32'd7);
    add_row(CMD_ENQ, 32'h8000_0001);
    add_row(CMD_INS, 32'd3);
    add_row(CMD_ENQ, 32'hFFFF_FFFE);
    add_row(CMD_INS, 32'd42);
    add_row(CMD_ENQ, 32'd9);
    add_row(CMD_INS, 32'h7FFF_FFFE);
    add_row(CMD_ENQ, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, ST_FULL, CNT_W'(DEPTH));
    add_row(CMD_INS, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, ST_FULL, CNT_W'(DEPTH));
    add_row(CMD_DEQ, 32'h0);
    add_row(CMD_CLR, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK, CNT_W'(0));
    add_row(CMD_DEQ, 32'h0, 1'b1, 32'h0, ST_EMPTY, CNT_W'(0));
    add_row(CMD_INS, 32'h0000_1234);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_cmd(directed_rows[i].op, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].want);

    // Random phases: fill-heavy, drain-heavy or balanced blocks
    bias = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) bias = $urandom_range(2);
      no_idle = (n >= 250 && n < 400);
      roll = $urandom_range(99);
      if (roll < 3) begin
        op = CMD_CLR;
      end else if (roll < (bias == 0 ? 25 : (bias == 1 ? 70 : 45))) begin
        op = CMD_DEQ;
      end else begin
        op = $urandom_range(2) == 0 ? CMD_ENQ : CMD_INS;
      end
      issue_cmd(op, pick_value(), 1'b0, none);
    end
    start   <= 1'b0;
    no_idle = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
